/* sv/kda_pkg.sv */
// kda_pkg: shared types and constants of the key debounce / auto-repeat block
// no dependencies; used by kda_step, the top, kda_tb_pkg and the testbench
`timescale 1ns / 1ps

package kda_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_GAP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_START = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_STEP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PAUSE        = 3'd4;

	localparam logic [7:0] RST_DOUBLE_GAP   = 8'd16;
	localparam logic [7:0] RST_LONG_PRESS   = 8'd24;
	localparam logic [7:0] RST_REPEAT_START = 8'd40;
	localparam logic [7:0] RST_RATE_STEP    = 8'd48;
	localparam logic [7:0] RST_PAUSE        = 8'd64;

	// item function codes
	localparam logic [1:0] FUNC_SAMPLE = 2'd0;
	localparam logic [1:0] FUNC_PAUSE  = 2'd1;
	localparam logic [1:0] FUNC_KILL   = 2'd2;
	localparam logic [1:0] FUNC_NONE   = 2'd3;

	// event kinds
	localparam logic [1:0] EV_FIRST   = 2'd0;
	localparam logic [1:0] EV_LONG    = 2'd1;
	localparam logic [1:0] EV_REPEAT  = 2'd2;
	localparam logic [1:0] EV_RELEASE = 2'd3;

	// key modes
	localparam logic [4:0] MODE_OFF    = 5'd0;
	localparam logic [4:0] MODE_DIV1   = 5'd1;
	localparam logic [4:0] MODE_DIV2   = 5'd2;
	localparam logic [4:0] MODE_DIV4   = 5'd4;
	localparam logic [4:0] MODE_DIV8   = 5'd8;
	localparam logic [4:0] MODE_DIV16  = 5'd16;
	localparam logic [4:0] MODE_START  = 5'd17;
	localparam logic [4:0] MODE_DELAY  = 5'd18;
	localparam logic [4:0] MODE_PAUSE  = 5'd19;
	localparam logic [4:0] MODE_KILLED = 5'd20;

	// ticks below which a release from divisor 16 keeps the press count
	localparam logic [7:0] QUICK_RELEASE_TICKS = 8'd16;

	typedef struct packed {
		logic [7:0] double_gap;
		logic [7:0] long_press;
		logic [7:0] repeat_start;
		logic [7:0] rate_step;
		logic [7:0] pause;
	} kda_cfg_t;

	typedef struct packed {
		logic [4:0] mode;
		logic [7:0] tick;
		logic [7:0] dcnt;
	} kda_ctl_t;

	localparam int CTL_W = $bits(kda_ctl_t);

endpackage

/* sv/kda_if.sv */
// kda_in_if / kda_out_if: valid/ready channels for sample words and event words
// depends on nothing
`timescale 1ns / 1ps

interface kda_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [3:0] key;
	logic       level;

	modport source (output valid, func, key, level, input ready);
	modport sink (input valid, func, key, level, output ready);
endinterface

interface kda_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_kind;
	logic [3:0] event_key;
	logic [7:0] press_count;

	modport source (output valid, event_kind, event_key, press_count, input ready);
	modport sink (input valid, event_kind, event_key, press_count, output ready);
endinterface

/* sv/kda_ram.sv */
// kda_ram: generic single-write, single-read RAM with registered read data
// depends on nothing
`timescale 1ns / 1ps

module kda_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [WIDTH-1:0]      wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output logic [WIDTH-1:0]      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* sv/kda_step.sv */
// kda_step: next-state and event logic for one key word
// depends on kda_pkg
`timescale 1ns / 1ps

module kda_step #(
	parameter int HISTORY_BITS = 8
) (
	input  kda_pkg::kda_cfg_t        cfg,
	input  logic [1:0]               func,
	input  logic                     level,
	input  logic [HISTORY_BITS-1:0]  hist_in,
	input  kda_pkg::kda_ctl_t        ctl_in,
	output logic [HISTORY_BITS-1:0]  hist_out,
	output kda_pkg::kda_ctl_t        ctl_out,
	output logic                     ev_valid,
	output logic [1:0]               ev_kind
);
	always_comb begin
		logic [HISTORY_BITS-1:0] h;
		logic [4:0] m;
		logic [7:0] c;
		logic [7:0] dc;
		logic [4:0] mask;
		h = {hist_in[HISTORY_BITS-2:0], level};
		m = ctl_in.mode;
		c = 8'(ctl_in.tick + 8'd1);
		dc = ctl_in.dcnt;
		ev_valid = 1'b0;
		ev_kind = kda_pkg::EV_FIRST;
		mask = 5'd0;

		unique case (func)
			kda_pkg::FUNC_PAUSE: begin
				hist_out = hist_in;
				ctl_out = '{mode: kda_pkg::MODE_PAUSE, tick: 8'd0, dcnt: ctl_in.dcnt};
			end
			kda_pkg::FUNC_KILL: begin
				hist_out = hist_in;
				ctl_out = '{mode: kda_pkg::MODE_KILLED, tick: ctl_in.tick, dcnt: 8'd0};
			end
			kda_pkg::FUNC_SAMPLE: begin
				// release
				if (m != kda_pkg::MODE_OFF && h == '0) begin
					if (m != kda_pkg::MODE_KILLED) begin
						ev_valid = 1'b1;
						ev_kind = kda_pkg::EV_RELEASE;
						if (!(m == kda_pkg::MODE_DIV16 && c < kda_pkg::QUICK_RELEASE_TICKS)) begin
							dc = 8'd0;
						end
					end
					c = 8'd0;
					m = kda_pkg::MODE_OFF;
				end
				unique case (m)
					kda_pkg::MODE_OFF: begin
						if (h == '1) begin
							m = kda_pkg::MODE_START;
							if (c > cfg.double_gap) begin
								dc = 8'd0;
							end
							c = 8'd0;
						end
					end
					kda_pkg::MODE_START: begin
						ev_valid = 1'b1;
						ev_kind = kda_pkg::EV_FIRST;
						dc = 8'(dc + 8'd1);
						m = kda_pkg::MODE_DELAY;
						c = 8'd0;
					end
					kda_pkg::MODE_DELAY: begin
						if (c == cfg.long_press) begin
							ev_valid = 1'b1;
							ev_kind = kda_pkg::EV_LONG;
						end
						if (c == cfg.repeat_start) begin
							m = kda_pkg::MODE_DIV16;
							c = 8'd0;
						end
					end
					kda_pkg::MODE_DIV1, kda_pkg::MODE_DIV2, kda_pkg::MODE_DIV4,
					kda_pkg::MODE_DIV8, kda_pkg::MODE_DIV16: begin
						if (m != kda_pkg::MODE_DIV1 && c >= cfg.rate_step) begin
							m = m >> 1;
							c = 8'd0;
						end
						mask = 5'(m - 5'd1);
						if ((c & {3'b000, mask}) == 8'd0) begin
							ev_valid = 1'b1;
							ev_kind = kda_pkg::EV_REPEAT;
						end
					end
					kda_pkg::MODE_PAUSE: begin
						if (c >= cfg.pause) begin
							m = kda_pkg::MODE_DIV8;
							c = 8'd0;
						end
					end
					default: begin
					end
				endcase
				hist_out = h;
				ctl_out = '{mode: m, tick: c, dcnt: dc};
			end
			default: begin
				hist_out = hist_in;
				ctl_out = ctl_in;
			end
		endcase
	end
endmodule

/* sv/key_debounce_autorepeat_top.sv */
// key_debounce_autorepeat_top: per-key debounce and auto-repeat engine
// depends on kda_pkg, kda_if (channels), kda_ram, kda_step
`timescale 1ns / 1ps

// Takes one word per clock on in_ch and gives at most one event word per
// input word on out_ch; a word passes from the read stage registers into the
// output register, which holds its event. The per-key state (history, mode,
// tick count, press count) lives in one RAM of KEYS entries with a registered
// read: a word reads its key at acceptance and writes it back from the read
// stage, and a word for the key just written takes the written value from a
// bypass register. Per-key valid bits cleared by reset stand for the zero
// state, so no clearing pass is needed and words are taken right after reset.
// in_ch.ready drops only while the output register holds an unclaimed event.
// Configuration writes take effect on the next cycle.

module key_debounce_autorepeat_top #(
	parameter int KEYS         = 16,
	parameter int HISTORY_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [kda_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kda_pkg::CFG_DATA_W-1:0]   cfg_data,
	kda_in_if.sink                           in_ch,
	kda_out_if.source                        out_ch
);
	localparam int KEY_AW = (KEYS > 1) ? $clog2(KEYS) : 1;
	localparam int ENT_W  = HISTORY_BITS + kda_pkg::CTL_W;

	kda_pkg::kda_cfg_t cfg_q;

	logic              s1_vld_q;
	logic [1:0]        func_s1;
	logic [3:0]        key_s1;
	logic [KEY_AW-1:0] idx_s1;
	logic              level_s1;
	logic              ok_s1;

	logic              adv;
	logic              ram_we;
	logic [ENT_W-1:0]  rdata;
	logic [ENT_W-1:0]  cur;
	logic [ENT_W-1:0]  nxt;
	logic [KEYS-1:0]   vld_q;
	logic              fwd_vld_q;
	logic [KEY_AW-1:0] fwd_idx_q;
	logic [ENT_W-1:0]  fwd_data_q;

	logic [HISTORY_BITS-1:0] hist_cur;
	logic [HISTORY_BITS-1:0] hist_nxt;
	kda_pkg::kda_ctl_t       ctl_cur;
	kda_pkg::kda_ctl_t       ctl_nxt;
	logic                    ev_valid;
	logic [1:0]              ev_kind;

	logic       out_vld_q;
	logic [1:0] kind_q;
	logic [3:0] evkey_q;
	logic [7:0] pcnt_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{double_gap: kda_pkg::RST_DOUBLE_GAP,
			           long_press: kda_pkg::RST_LONG_PRESS,
			           repeat_start: kda_pkg::RST_REPEAT_START,
			           rate_step: kda_pkg::RST_RATE_STEP,
			           pause: kda_pkg::RST_PAUSE};
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				kda_pkg::CFG_DOUBLE_GAP:   cfg_q.double_gap <= cfg_data;
				kda_pkg::CFG_LONG_PRESS:   cfg_q.long_press <= cfg_data;
				kda_pkg::CFG_REPEAT_START: cfg_q.repeat_start <= cfg_data;
				kda_pkg::CFG_RATE_STEP:    cfg_q.rate_step <= cfg_data;
				kda_pkg::CFG_PAUSE:        cfg_q.pause <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign adv = !out_vld_q || out_ch.ready;
	assign in_ch.ready = adv;

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (adv) begin
			s1_vld_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_ch.valid) begin
			func_s1  <= in_ch.func;
			key_s1   <= in_ch.key;
			idx_s1   <= KEY_AW'(in_ch.key);
			level_s1 <= in_ch.level;
			ok_s1    <= (32'(in_ch.key) < KEYS) && (in_ch.func != kda_pkg::FUNC_NONE);
		end
	end

	kda_ram #(
		.WIDTH (ENT_W),
		.DEPTH (KEYS)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_s1),
		.wdata (nxt),
		.re    (adv && in_ch.valid),
		.raddr (KEY_AW'(in_ch.key)),
		.rdata (rdata)
	);

	// entry select: bypass, stored, or never-written zero state
	always_comb begin
		if (fwd_vld_q && fwd_idx_q == idx_s1) begin
			cur = fwd_data_q;
		end else if (vld_q[idx_s1]) begin
			cur = rdata;
		end else begin
			cur = '0;
		end
	end

	assign hist_cur = cur[ENT_W-1 -: HISTORY_BITS];
	assign ctl_cur  = kda_pkg::kda_ctl_t'(cur[kda_pkg::CTL_W-1:0]);

	kda_step #(
		.HISTORY_BITS (HISTORY_BITS)
	) u_step (
		.cfg      (cfg_q),
		.func     (func_s1),
		.level    (level_s1),
		.hist_in  (hist_cur),
		.ctl_in   (ctl_cur),
		.hist_out (hist_nxt),
		.ctl_out  (ctl_nxt),
		.ev_valid (ev_valid),
		.ev_kind  (ev_kind)
	);

	assign nxt    = {hist_nxt, ctl_nxt};
	assign ram_we = adv && s1_vld_q && ok_s1;

	// valid bits and write bypass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			fwd_vld_q <= 1'b0;
		end else if (ram_we) begin
			vld_q[idx_s1] <= 1'b1;
			fwd_vld_q     <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			fwd_idx_q  <= idx_s1;
			fwd_data_q <= nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= s1_vld_q && ok_s1 && ev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_vld_q) begin
			kind_q  <= ev_kind;
			evkey_q <= key_s1;
			pcnt_q  <= ctl_nxt.dcnt;
		end
	end

	assign out_ch.valid       = out_vld_q;
	assign out_ch.event_kind  = kind_q;
	assign out_ch.event_key   = evkey_q;
	assign out_ch.press_count = pcnt_q;

	a_out_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(s1_vld_q && ok_s1))
		else $error("event word without a word in the read stage");

	a_bypass_tracks_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (fwd_vld_q && fwd_idx_q == $past(idx_s1) && fwd_data_q == $past(nxt)))
		else $error("bypass register does not hold the last write");

	a_valid_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> vld_q[$past(idx_s1)])
		else $error("written key not marked valid");

endmodule

/* tb/sv/kda_tb_pkg.sv */
// kda_tb_pkg: event scoreboard for the key debounce / auto-repeat testbench
// holds a per-key model of the block and the queue of predicted event words
// depends on kda_pkg
`timescale 1ns / 1ps

package kda_tb_pkg;
	import kda_pkg::*;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] key;
		logic [7:0] count;
	} key_event_t;

	class kda_scoreboard;
		logic [7:0]  key_hist [16];
		logic [4:0]  key_state [16];
		logic [7:0]  key_ticks [16];
		logic [7:0]  key_taps [16];
		kda_cfg_t    cfg;
		key_event_t  pending_events [$];
		int          errors;

		function new();
			cfg.double_gap   = RST_DOUBLE_GAP;
			cfg.long_press   = RST_LONG_PRESS;
			cfg.repeat_start = RST_REPEAT_START;
			cfg.rate_step    = RST_RATE_STEP;
			cfg.pause        = RST_PAUSE;
			for (int i = 0; i < 16; i++) begin
				key_hist[i]  = '0;
				key_state[i] = MODE_OFF;
				key_ticks[i] = '0;
				key_taps[i]  = '0;
			end
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
			case (idx)
				CFG_DOUBLE_GAP:   cfg.double_gap = data;
				CFG_LONG_PRESS:   cfg.long_press = data;
				CFG_REPEAT_START: cfg.repeat_start = data;
				CFG_RATE_STEP:    cfg.rate_step = data;
				CFG_PAUSE:        cfg.pause = data;
				default: ;
			endcase
		endfunction

		function int outstanding();
			return pending_events.size();
		endfunction

		// one raw sample for key k: debounce, state step, optional event
		function void advance_key(logic [3:0] k, logic level);
			logic [7:0] h;
			logic [4:0] m;
			logic [7:0] c;
			logic [7:0] div_mask;
			bit         fire;
			key_event_t ev;
			h = {key_hist[k][6:0], level};
			m = key_state[k];
			c = key_ticks[k] + 8'd1;
			fire = 1'b0;
			ev.kind = EV_FIRST;
			key_hist[k] = h;
			if (m != MODE_OFF && h == 8'h00) begin
				if (m != MODE_KILLED) begin
					fire = 1'b1;
					ev.kind = EV_RELEASE;
					if (!(m == MODE_DIV16 && c < QUICK_RELEASE_TICKS))
						key_taps[k] = '0;
				end
				c = '0;
				m = MODE_OFF;
			end
			case (m)
				MODE_OFF: begin
					if (h == 8'hFF) begin
						m = MODE_START;
						if (c > cfg.double_gap)
							key_taps[k] = '0;
						c = '0;
					end
				end
				MODE_START: begin
					fire = 1'b1;
					ev.kind = EV_FIRST;
					key_taps[k] = key_taps[k] + 8'd1;
					m = MODE_DELAY;
					c = '0;
				end
				MODE_DELAY: begin
					if (c == cfg.long_press) begin
						fire = 1'b1;
						ev.kind = EV_LONG;
					end
					if (c == cfg.repeat_start) begin
						m = MODE_DIV16;
						c = '0;
					end
				end
				MODE_DIV16, MODE_DIV8, MODE_DIV4, MODE_DIV2, MODE_DIV1: begin
					if (m != MODE_DIV1 && c >= cfg.rate_step) begin
						m = m >> 1;
						c = '0;
					end
					div_mask = {3'b000, m} - 8'd1;
					if ((c & div_mask) == 8'd0) begin
						fire = 1'b1;
						ev.kind = EV_REPEAT;
					end
				end
				MODE_PAUSE: begin
					if (c >= cfg.pause) begin
						m = MODE_DIV8;
						c = '0;
					end
				end
				default: ;
			endcase
			key_state[k] = m;
			key_ticks[k] = c;
			if (fire) begin
				ev.key = k;
				ev.count = key_taps[k];
				pending_events.push_back(ev);
			end
		endfunction

		function void note_word(logic [1:0] func, logic [3:0] k, logic level);
			case (func)
				FUNC_SAMPLE: advance_key(k, level);
				FUNC_PAUSE: begin
					key_state[k] = MODE_PAUSE;
					key_ticks[k] = '0;
				end
				FUNC_KILL: begin
					key_state[k] = MODE_KILLED;
					key_taps[k] = '0;
				end
				default: ;
			endcase
		endfunction

		function void check_event(logic [1:0] kind, logic [3:0] k, logic [7:0] count);
			key_event_t want;
			if (pending_events.size() == 0) begin
				$error("event word with nothing pending: kind %0d key %0d count %0d",
					kind, k, count);
				errors++;
				return;
			end
			want = pending_events.pop_front();
			if (want.kind != kind) begin
				$error("event_kind: expected %0d, actual %0d", want.kind, kind);
				errors++;
			end
			if (want.key != k) begin
				$error("event_key: expected %0d, actual %0d", want.key, k);
				errors++;
			end
			if (want.count != count) begin
				$error("press_count: expected %0d, actual %0d", want.count, count);
				errors++;
			end
		endfunction
	endclass

endpackage

/* tb/sv/testbench.sv */
// testbench: drives sample, pause and kill words into key_debounce_autorepeat_top
// under several register settings and checks every event word on the scoreboard
// depends on kda_pkg, kda_if, kda_tb_pkg and the block's rtl
`timescale 1ns / 1ps

module testbench;
	import kda_pkg::*;
	import kda_tb_pkg::*;

	localparam int WATCHDOG_LIMIT   = 3000;
	localparam int SETTLE_CYCLES    = 4;
	localparam int LONG_HOLD_CYCLES = 250;
	localparam int POOL             = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	kda_in_if  in_ch ();
	kda_out_if out_ch ();

	key_debounce_autorepeat_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	kda_scoreboard sb;
	int            idle_cycles = 0;
	bit            long_hold_req = 1'b0;
	int            burst_left = 0;
	logic [3:0]    pool [POOL];
	logic          hold_level [16];
	int            run_left [16];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_event(out_ch.event_kind, out_ch.event_key, out_ch.press_count);
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// event sink: random stall modes, plus one long hold on request
	initial begin
		int stall_mode;
		int mode_left;
		int hold_left;
		stall_mode = 0;
		mode_left = 0;
		hold_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 2);
					mode_left = $urandom_range(8, 80);
				end
				mode_left--;
				case (stall_mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= 1'($urandom_range(0, 1));
					default: out_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic send_word(input logic [1:0] func, input logic [3:0] k, input logic level);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.func <= func;
		in_ch.key <= k;
		in_ch.level <= level;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_word(func, k, level);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_cfg(input logic [7:0] gap_ticks, input logic [7:0] long_ticks,
			input logic [7:0] start_ticks, input logic [7:0] step_ticks,
			input logic [7:0] pause_len, input bit poke_unused);
		logic [CFG_IDX_W-1:0] idx [6];
		logic [7:0]           val [6];
		logic [7:0]           junk;
		int                   n;
		junk = 8'($urandom_range(0, 255));
		idx = '{CFG_DOUBLE_GAP, CFG_LONG_PRESS, CFG_REPEAT_START, CFG_RATE_STEP,
			CFG_PAUSE, CFG_UNUSED};
		val = '{gap_ticks, long_ticks, start_ticks, step_ticks, pause_len, junk};
		n = poke_unused ? 6 : 5;
		for (int i = 0; i < n; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			sb.write_reg(idx[i], val[i]);
		end
		cfg_wr_en <= 1'b0;
	endtask

	// mostly press/hold/release runs on a few keys, with bounce and noise
	task automatic run_random(input int count);
		int         r;
		int         n;
		logic [3:0] k;
		logic [1:0] f;
		logic       lvl;
		for (int i = 0; i < POOL; i++)
			pool[i] = 4'($urandom_range(0, 15));
		n = 0;
		while (n < count) begin
			r = $urandom_range(0, 99);
			k = pool[$urandom_range(0, POOL - 1)];
			f = FUNC_SAMPLE;
			lvl = 1'($urandom_range(0, 1));
			if (r < 3) begin
				f = FUNC_PAUSE;
			end else if (r < 5) begin
				f = FUNC_KILL;
			end else if (r < 6) begin
				f = FUNC_NONE;
				k = 4'($urandom_range(0, 15));
			end else if (r < 12) begin
				k = 4'($urandom_range(0, 15));
			end else begin
				if (run_left[k] == 0) begin
					hold_level[k] = ~hold_level[k];
					run_left[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90)
						: $urandom_range(1, 20);
				end
				run_left[k]--;
				lvl = hold_level[k] ^ ($urandom_range(0, 24) == 0);
			end
			send_word(f, k, lvl);
			if (f != FUNC_NONE)
				n++;
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_DOUBLE_GAP;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.func = FUNC_SAMPLE;
		in_ch.key = '0;
		in_ch.level = 1'b0;
		for (int i = 0; i < 16; i++) begin
			hold_level[i] = 1'b0;
			run_left[i] = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// press key 15, get first press, kill it, then release silently
		repeat (9) send_word(FUNC_SAMPLE, 4'd15, 1'b1);
		send_word(FUNC_KILL, 4'd15, 1'b0);
		repeat (8) send_word(FUNC_SAMPLE, 4'd15, 1'b0);
		// paused idle key releases on its next sample
		send_word(FUNC_PAUSE, 4'd0, 1'b1);
		send_word(FUNC_SAMPLE, 4'd0, 1'b0);
		send_word(FUNC_NONE, 4'd7, 1'b1);

		drain();
		apply_cfg(8'd255, 8'd2, 8'd4, 8'd20, 8'd5, 1'b0);
		run_random(110);

		drain();
		apply_cfg(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		long_hold_req = 1'b1;
		run_random(90);

		drain();
		apply_cfg(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
		run_random(80);

		drain();
		apply_cfg(8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
			8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
			8'($urandom_range(0, 12)), 1'b0);
		run_random(110);

		drain();
		apply_cfg(8'($urandom_range(0, 40)), 8'($urandom_range(0, 10)),
			8'($urandom_range(0, 16)), 8'($urandom_range(0, 30)),
			8'($urandom_range(0, 20)), 1'b1);
		run_random(110);

		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* filelist.f */
sv/kda_pkg.sv
sv/kda_if.sv
sv/kda_ram.sv
sv/kda_step.sv
sv/key_debounce_autorepeat_top.sv
tb/sv/kda_tb_pkg.sv
tb/sv/testbench.sv
